// File: hdl/assert_macros.svh
// concurrent assertion helpers, clocked on the rising edge and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RFC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rfc_pkg.sv
package rfc_pkg;

   localparam int FUNC_W     = 2;
   localparam int STAT_W     = 2;
   localparam int EDGE_W     = 8;
   localparam int REF_W      = 16;
   localparam int SLOW_W     = 8;
   localparam int PHASE_W    = 8;
   localparam int LIMIT_W    = 7;
   localparam int FREQ_W     = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_CAPTURE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

   localparam logic [STAT_W-1:0] STAT_STARTED   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RESTARTED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MEASURED  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DIV_ZERO  = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_REF     = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_LIMIT = 1'd1;

   localparam logic [REF_W-1:0]   MIN_REF_RESET     = 16'd4000;
   localparam logic [LIMIT_W-1:0] PHASE_LIMIT_RESET = 7'd20;

   // request tdata layout
   localparam int REQ_DATA_W    = 40;
   localparam int REQ_SIG_LSB   = 0;
   localparam int REQ_REF_LSB   = 8;
   localparam int REQ_LEVEL_BIT = 24;
   localparam int REQ_OVF_BIT   = 25;
   localparam int REQ_SLOW_LSB  = 26;

   // response tdata layout
   localparam int RSP_DATA_W    = 56;
   localparam int RSP_EDGES_LSB = 0;
   localparam int RSP_PHASE_LSB = 24;
   localparam int RSP_FREQ_LSB  = 32;
   localparam int RSP_SAT_BIT   = 48;

   typedef struct packed {
      logic              done;
      logic              div_zero;
      logic              sat;
      logic [FREQ_W-1:0] freq;
   } calc_res_type;

endpackage

// File: hdl/rfc_mul.sv
module rfc_mul #(
   parameter int A_W = 24,
   parameter int B_W = 17
) (
   input  logic             clock,
   input  logic [A_W-1:0]   op_a,
   input  logic [B_W-1:0]   op_b,
   output logic [A_W+B_W-1:0] product
);

   logic [A_W+B_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
   end

   assign product = prod_ff;

endmodule

// File: hdl/rfc_calc.sv
module rfc_calc #(
   parameter int REF_SCALE = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rfc_pkg::EDGE_W-1:0]   edges,
   input  logic [rfc_pkg::REF_W-1:0]    refs,
   input  logic [rfc_pkg::SLOW_W-1:0]   slow_delta,
   input  logic [rfc_pkg::REF_W-1:0]    ref_cal,
   output rfc_pkg::calc_res_type        res
);

   import rfc_pkg::*;

   localparam int SCALE_W = $clog2(REF_SCALE + 1);
   localparam int A_W     = REF_W + EDGE_W;
   localparam int B_W     = (SCALE_W > SLOW_W) ? SCALE_W : SLOW_W;
   localparam int P_W     = A_W + B_W;
   localparam int DIV_W   = REF_W + SLOW_W;
   localparam int NUM_W   = A_W + SCALE_W + 1;
   localparam int CNT_W   = $clog2(NUM_W);

   typedef enum logic [2:0] {
      C_IDLE,
      C_MUL_EDGE,
      C_MUL_SCALE,
      C_MUL_DIV,
      C_LOAD,
      C_DIV,
      C_FIN
   } calc_state_type;

   calc_state_type      state_ff, state_in;
   logic [EDGE_W-1:0]   edges_ff, edges_in;
   logic [REF_W-1:0]    refs_ff, refs_in;
   logic [SLOW_W-1:0]   slow_ff, slow_in;
   logic [REF_W-1:0]    cal_ff, cal_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [NUM_W-1:0]    nq_ff, nq_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic                zero_ff, zero_in;
   logic                sat_ff, sat_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;

   logic [A_W-1:0]      mul_a;
   logic [B_W-1:0]      mul_b;
   logic [P_W-1:0]      prod;
   logic [DIV_W:0]      rem_sh;
   logic [DIV_W:0]      rem_diff;
   logic                rem_ge;
   logic                q_over;

   rfc_mul #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         C_MUL_EDGE: begin
            mul_a = A_W'(cal_ff);
            mul_b = B_W'(edges_ff);
         end
         C_MUL_SCALE: begin
            mul_a = prod[A_W-1:0];
            mul_b = B_W'(REF_SCALE);
         end
         C_MUL_DIV: begin
            mul_a = A_W'(refs_ff);
            mul_b = B_W'(slow_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // restoring divider step
   assign rem_sh   = {rem_ff, nq_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, div_ff};
   assign rem_ge   = (rem_sh >= {1'b0, div_ff});
   assign q_over   = |nq_ff[NUM_W-1:FREQ_W];

   always_comb begin
      state_in = state_ff;
      edges_in = edges_ff;
      refs_in  = refs_ff;
      slow_in  = slow_ff;
      cal_in   = cal_ff;
      num_in   = num_ff;
      nq_in    = nq_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      sat_in   = sat_ff;
      freq_in  = freq_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               edges_in = edges;
               refs_in  = refs;
               slow_in  = slow_delta;
               cal_in   = ref_cal;
               state_in = C_MUL_EDGE;
            end
         end
         C_MUL_EDGE: begin
            state_in = C_MUL_SCALE;
         end
         C_MUL_SCALE: begin
            state_in = C_MUL_DIV;
         end
         C_MUL_DIV: begin
            num_in   = NUM_W'(prod);
            state_in = C_LOAD;
         end
         C_LOAD: begin
            div_in = prod[DIV_W-1:0];
            rem_in = '0;
            cnt_in = '0;
            if (prod[DIV_W-1:0] == '0) begin
               zero_in  = 1'b1;
               sat_in   = 1'b0;
               freq_in  = '0;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               // rounding term: half the divisor
               nq_in    = num_ff + NUM_W'(prod[DIV_W-1:1]);
               zero_in  = 1'b0;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            rem_in = rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            nq_in  = {nq_ff[NUM_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = C_FIN;
            end
         end
         C_FIN: begin
            sat_in   = q_over;
            freq_in  = q_over ? '1 : nq_ff[FREQ_W-1:0];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      edges_ff <= edges_in;
      refs_ff  <= refs_in;
      slow_ff  <= slow_in;
      cal_ff   <= cal_in;
      num_ff   <= num_in;
      nq_ff    <= nq_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      zero_ff  <= zero_in;
      sat_ff   <= sat_in;
      freq_ff  <= freq_in;
   end

   assign res.done     = done_ff;
   assign res.div_zero = zero_ff;
   assign res.sat      = sat_ff;
   assign res.freq     = freq_ff;

endmodule

// File: hdl/reciprocal_frequency_counter_top.sv
// Reciprocal frequency counter with quadrature direction tracking. Each request transfer
// carries a kind in req_tuser: signal capture, measurement timeout or reference calibration
// tick. Timeouts and ticks leave the block idle; a capture that starts or restarts a window
// skips the calculator; its response is offered once the output register is free. A capture
// that completes a window computes the rounded frequency on one shared multiplier followed by
// a restoring divider that retires one quotient bit per cycle, so the block holds req_tready
// low until the response is offered and the next request is taken. A waiting response does
// not block requests that produce none. Configuration writes take effect at once and are
// meant for idle periods.
module reciprocal_frequency_counter_top #(
   parameter int REF_SCALE = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sig_count, ref_capture, quadrature_level, sig_overflow, slow_count, zero pad
   input  logic [rfc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func
   input  logic [rfc_pkg::FUNC_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // signal_edges, reference_counts, phase_count, frequency, freq_saturated, zero pad
   output logic [rfc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [rfc_pkg::STAT_W-1:0]         rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [rfc_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [rfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import rfc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_CALC,
      ST_EMIT
   } top_state_type;

   top_state_type              state_ff, state_in;
   logic [REF_W-1:0]           min_ref_ff, min_ref_in;
   logic [LIMIT_W-1:0]         limit_ff, limit_in;
   logic                       running_ff, running_in;
   logic signed [PHASE_W-1:0]  phase_ff, phase_in;
   logic [EDGE_W-1:0]          sig_start_ff, sig_start_in;
   logic [REF_W-1:0]           ref_start_ff, ref_start_in;
   logic                       gate_ff, gate_in;
   logic [SLOW_W-1:0]          last_slow_ff, last_slow_in;
   logic [REF_W-1:0]           last_ref_ff, last_ref_in;
   logic [SLOW_W-1:0]          slow_delta_ff, slow_delta_in;
   logic [REF_W-1:0]           cal_ff, cal_in;
   logic [STAT_W-1:0]          pend_stat_ff, pend_stat_in;
   logic [EDGE_W-1:0]          pend_edges_ff, pend_edges_in;
   logic [REF_W-1:0]           pend_refs_ff, pend_refs_in;
   logic [PHASE_W-1:0]         pend_phase_ff, pend_phase_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]          rsp_user_ff, rsp_user_in;

   logic                       req_xfer;
   logic [EDGE_W-1:0]          in_sig;
   logic [REF_W-1:0]           in_ref;
   logic                       in_level;
   logic                       in_ovf;
   logic [SLOW_W-1:0]          in_slow;
   logic [EDGE_W-1:0]          edges_now;
   logic [REF_W-1:0]           refs_now;
   logic                       gate_pass;
   logic signed [PHASE_W-1:0]  lim;
   logic signed [PHASE_W-1:0]  phase_step;
   logic                       out_free;
   logic                       measured;
   logic [STAT_W-1:0]          emit_stat;
   logic [FREQ_W-1:0]          emit_freq;
   logic                       emit_sat;
   calc_res_type               calc_res;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign in_sig   = req_tdata[REQ_SIG_LSB +: EDGE_W];
   assign in_ref   = req_tdata[REQ_REF_LSB +: REF_W];
   assign in_level = req_tdata[REQ_LEVEL_BIT];
   assign in_ovf   = req_tdata[REQ_OVF_BIT];
   assign in_slow  = req_tdata[REQ_SLOW_LSB +: SLOW_W];

   assign edges_now = in_sig - sig_start_ff;
   assign refs_now  = in_ref - ref_start_ff;
   assign gate_pass = gate_ff || (refs_now >= min_ref_ff);

   // saturating direction count
   assign lim = signed'({1'b0, limit_ff});
   always_comb begin
      phase_step = phase_ff;
      if (in_level) begin
         if (phase_ff < lim) begin
            phase_step = phase_ff + 8'sd1;
         end
      end else begin
         if (phase_ff > -lim) begin
            phase_step = phase_ff - 8'sd1;
         end
      end
   end

   rfc_calc #(
      .REF_SCALE (REF_SCALE)
   ) u_calc (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == ST_LAUNCH),
      .edges      (pend_edges_ff),
      .refs       (pend_refs_ff),
      .slow_delta (slow_delta_ff),
      .ref_cal    (cal_ff),
      .res        (calc_res)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign measured  = (pend_stat_ff == STAT_MEASURED);
   assign emit_stat = (measured && calc_res.div_zero) ? STAT_DIV_ZERO : pend_stat_ff;
   assign emit_freq = measured ? calc_res.freq : '0;
   assign emit_sat  = measured && calc_res.sat;

   always_comb begin
      state_in      = state_ff;
      min_ref_in    = min_ref_ff;
      limit_in      = limit_ff;
      running_in    = running_ff;
      phase_in      = phase_ff;
      sig_start_in  = sig_start_ff;
      ref_start_in  = ref_start_ff;
      gate_in       = gate_ff;
      last_slow_in  = last_slow_ff;
      last_ref_in   = last_ref_ff;
      slow_delta_in = slow_delta_ff;
      cal_in        = cal_ff;
      pend_stat_in  = pend_stat_ff;
      pend_edges_in = pend_edges_ff;
      pend_refs_in  = pend_refs_ff;
      pend_phase_in = pend_phase_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_REF:     min_ref_in = csr_wdata[REF_W-1:0];
            CSR_PHASE_LIMIT: limit_in   = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  FUNC_TIMEOUT: begin
                     running_in = 1'b0;
                     phase_in   = '0;
                     gate_in    = 1'b1;
                  end
                  FUNC_TICK: begin
                     slow_delta_in = in_slow - last_slow_ff;
                     last_slow_in  = in_slow;
                     cal_in        = in_ref - last_ref_ff;
                     last_ref_in   = in_ref;
                  end
                  FUNC_CAPTURE: begin
                     if (gate_pass) begin
                        phase_in      = phase_step;
                        pend_phase_in = phase_step;
                        sig_start_in  = in_sig;
                        ref_start_in  = in_ref;
                        gate_in       = 1'b0;
                        running_in    = 1'b1;
                        pend_edges_in = '0;
                        pend_refs_in  = '0;
                        if (!running_ff) begin
                           pend_stat_in = STAT_STARTED;
                           state_in     = ST_EMIT;
                        end else if (in_ovf) begin
                           pend_stat_in = STAT_RESTARTED;
                           state_in     = ST_EMIT;
                        end else begin
                           pend_stat_in  = STAT_MEASURED;
                           pend_edges_in = edges_now;
                           pend_refs_in  = refs_now;
                           state_in      = ST_LAUNCH;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LAUNCH: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (calc_res.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = emit_stat;
               rsp_data_in  = RSP_DATA_W'({emit_sat, emit_freq, pend_phase_ff,
                                           pend_refs_ff, pend_edges_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_ref_ff    <= MIN_REF_RESET;
         limit_ff      <= PHASE_LIMIT_RESET;
         running_ff    <= 1'b0;
         phase_ff      <= '0;
         sig_start_ff  <= '0;
         ref_start_ff  <= '0;
         gate_ff       <= 1'b1;
         last_slow_ff  <= '0;
         last_ref_ff   <= '0;
         slow_delta_ff <= '0;
         cal_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_ref_ff    <= min_ref_in;
         limit_ff      <= limit_in;
         running_ff    <= running_in;
         phase_ff      <= phase_in;
         sig_start_ff  <= sig_start_in;
         ref_start_ff  <= ref_start_in;
         gate_ff       <= gate_in;
         last_slow_ff  <= last_slow_in;
         last_ref_ff   <= last_ref_in;
         slow_delta_ff <= slow_delta_in;
         cal_ff        <= cal_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_stat_ff  <= pend_stat_in;
      pend_edges_ff <= pend_edges_in;
      pend_refs_ff  <= pend_refs_in;
      pend_phase_ff <= pend_phase_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: hdl/rfc_checker.sv
`include "assert_macros.svh"

module rfc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [rfc_pkg::STAT_W-1:0]     rsp_tuser
);

   import rfc_pkg::*;

   logic [EDGE_W-1:0]  chk_edges;
   logic [PHASE_W-1:0] chk_phase;
   logic [FREQ_W-1:0]  chk_freq;
   logic               chk_sat;
   logic               chk_window_open;

   assign chk_edges = rsp_tdata[RSP_EDGES_LSB +: EDGE_W];
   assign chk_phase = rsp_tdata[RSP_PHASE_LSB +: PHASE_W];
   assign chk_freq  = rsp_tdata[RSP_FREQ_LSB +: FREQ_W];
   assign chk_sat   = rsp_tdata[RSP_SAT_BIT];
   assign chk_window_open = (rsp_tuser == STAT_STARTED) || (rsp_tuser == STAT_RESTARTED);

   `RFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   `RFC_ASSERT_SAME(a_start_empty, clock, reset, rsp_tvalid && chk_window_open, chk_edges == '0 && chk_freq == '0 && !chk_sat, "start or restart carries measurement data")

   `RFC_ASSERT_SAME(a_sat_clamp, clock, reset, rsp_tvalid && chk_sat, chk_freq == '1 && rsp_tuser == STAT_MEASURED, "saturation without clamped frequency")

   `RFC_ASSERT_SAME(a_zero_div, clock, reset, rsp_tvalid && rsp_tuser == STAT_DIV_ZERO, chk_freq == '0 && !chk_sat, "zero divisor with nonzero frequency")

   `RFC_ASSERT_SAME(a_phase_range, clock, reset, rsp_tvalid, chk_phase != 8'h80, "phase count out of range")

endmodule

bind reciprocal_frequency_counter_top rfc_checker u_rfc_checker (.*);

// File: tb/tb_reciprocal_frequency_counter_top.sv
`timescale 1ns / 100ps

module tb_reciprocal_frequency_counter_top;
   import rfc_pkg::*;

   localparam int REF_SCALE       = 256;
   localparam int IDLE_PCT        = 35;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int NUM_PHASES      = 8;
   localparam int DRAIN_CYCLES    = 60;
   localparam int DRAIN_GUARD     = 20000;
   localparam int RSP_REFS_LSB    = RSP_EDGES_LSB + EDGE_W;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [EDGE_W-1:0] sig;
      logic [REF_W-1:0]  refc;
      logic              level;
      logic              ovf;
      logic [SLOW_W-1:0] slow;
   } capture_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [EDGE_W-1:0]  edges;
      logic [REF_W-1:0]   refs;
      logic [PHASE_W-1:0] phase;
      logic [FREQ_W-1:0]  freq;
      logic               sat;
   } window_result_type;

   typedef struct packed {
      capture_item_type  item;
      logic              typed;
      window_result_type res;
   } stim_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // counter state as the block should hold it
   logic [REF_W-1:0]   min_ref_cfg;
   logic [LIMIT_W-1:0] limit_cfg;
   logic               win_running;
   logic               win_gate;
   int                 phase_acc;
   logic [EDGE_W-1:0]  sig_mark;
   logic [REF_W-1:0]   ref_mark;
   logic [SLOW_W-1:0]  slow_prev;
   logic [SLOW_W-1:0]  slow_span;
   logic [REF_W-1:0]   tick_prev;
   logic [REF_W-1:0]   tick_span;

   window_result_type pending_results[$];
   stim_row_type      directed_rows[$];

   bit no_idle = 1'b0;
   int errors = 0;
   int items_sent = 0;
   int items_effective = 0;
   int results_seen = 0;
   int sat_seen = 0;
   int settings_used = 1;
   int status_hits[4] = '{0, 0, 0, 0};

   reciprocal_frequency_counter_top #(
      .REF_SCALE(REF_SCALE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic predict_window(input capture_item_type it, output bit produced,
                                 output bit taken, output window_result_type res);
      longint unsigned divisor;
      longint unsigned num;
      longint unsigned quot;
      logic [REF_W-1:0] ref_gap;
      int lim;
      produced = 1'b0;
      taken = 1'b1;
      res = '0;
      lim = int'(limit_cfg);
      ref_gap = it.refc - ref_mark;
      case (it.func)
         FUNC_TIMEOUT: begin
            win_running = 1'b0;
            phase_acc = 0;
            win_gate = 1'b1;
         end
         FUNC_TICK: begin
            slow_span = it.slow - slow_prev;
            slow_prev = it.slow;
            tick_span = it.refc - tick_prev;
            tick_prev = it.refc;
         end
         FUNC_CAPTURE: begin
            if (!win_gate && ref_gap < min_ref_cfg) begin
               taken = 1'b0;
            end else begin
               if (it.level) begin
                  if (phase_acc < lim) phase_acc++;
               end else if (phase_acc > -lim) begin
                  phase_acc--;
               end
               if (!win_running) begin
                  win_running = 1'b1;
                  res.status = STAT_STARTED;
               end else if (it.ovf) begin
                  res.status = STAT_RESTARTED;
               end else begin
                  res.edges = it.sig - sig_mark;
                  res.refs = ref_gap;
                  divisor = 64'(slow_span) * 64'(res.refs);
                  if (divisor == 0) begin
                     res.status = STAT_DIV_ZERO;
                  end else begin
                     res.status = STAT_MEASURED;
                     num = 64'(res.edges) * 64'(REF_SCALE) * 64'(tick_span) + divisor / 2;
                     quot = num / divisor;
                     if (quot > 64'hFFFF) begin
                        res.freq = '1;
                        res.sat = 1'b1;
                     end else begin
                        res.freq = quot[FREQ_W-1:0];
                     end
                  end
               end
               sig_mark = it.sig;
               ref_mark = it.refc;
               win_gate = 1'b0;
               res.phase = phase_acc[PHASE_W-1:0];
               produced = 1'b1;
            end
         end
         default: taken = 1'b0;
      endcase
   endtask

   task automatic push_item(input capture_item_type it, input logic typed,
                            input window_result_type typed_res, output bit taken);
      window_result_type res;
      logic [REQ_DATA_W-1:0] word;
      bit produced;
      word = '0;
      word[REQ_SIG_LSB +: EDGE_W] = it.sig;
      word[REQ_REF_LSB +: REF_W] = it.refc;
      word[REQ_LEVEL_BIT] = it.level;
      word[REQ_OVF_BIT] = it.ovf;
      word[REQ_SLOW_LSB +: SLOW_W] = it.slow;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.func;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_window(it, produced, taken, res);
      if (produced) pending_results.push_back(typed ? typed_res : res);
      items_sent++;
      if (taken) items_effective++;
   endtask

   task automatic settle();
      int guard;
      guard = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MIN_REF) min_ref_cfg = REF_W'(value);
      else limit_cfg = LIMIT_W'(value);
   endtask

   task automatic add_row(input logic [FUNC_W-1:0] func, input int sig, input int refc,
                          input int level, input int ovf, input int slow,
                          input logic typed, input window_result_type res);
      stim_row_type row;
      row.item.func = func;
      row.item.sig = EDGE_W'(sig);
      row.item.refc = REF_W'(refc);
      row.item.level = level[0];
      row.item.ovf = ovf[0];
      row.item.slow = SLOW_W'(slow);
      row.typed = typed;
      row.res = res;
      directed_rows.push_back(row);
   endtask

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_check
      window_result_type want;
      window_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.edges = rsp_tdata[RSP_EDGES_LSB +: EDGE_W];
         got.refs = rsp_tdata[RSP_REFS_LSB +: REF_W];
         got.phase = rsp_tdata[RSP_PHASE_LSB +: PHASE_W];
         got.freq = rsp_tdata[RSP_FREQ_LSB +: FREQ_W];
         got.sat = rsp_tdata[RSP_SAT_BIT];
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with none expected, status %0d", $time,
                     got.status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            status_hits[want.status]++;
            if (want.sat) sat_seen++;
            compare_field("status", want.status, got.status);
            compare_field("signal_edges", want.edges, got.edges);
            compare_field("reference_counts", want.refs, got.refs);
            compare_field("phase_count", $signed(want.phase), $signed(got.phase));
            compare_field("frequency", want.freq, got.freq);
            compare_field("freq_saturated", want.sat, got.sat);
         end
      end
   end

   initial begin : stimulus
      capture_item_type it;
      bit taken;
      int counted;
      int span;
      int pick;
      int min_plan[NUM_PHASES];
      int limit_plan[NUM_PHASES];

      min_ref_cfg = MIN_REF_RESET;
      limit_cfg = PHASE_LIMIT_RESET;
      win_running = 1'b0;
      win_gate = 1'b1;
      phase_acc = 0;
      sig_mark = '0;
      ref_mark = '0;
      slow_prev = '0;
      slow_span = '0;
      tick_prev = '0;
      tick_span = '0;

      min_plan = '{0, 65535, 1000, 4000, 300, 0, 0, 0};
      limit_plan = '{127, 1, 0, 20, 127, 0, 0, 0};
      for (int p = 5; p < NUM_PHASES; p++) begin
         min_plan[p] = int'($urandom_range(0, 8000));
         limit_plan[p] = int'($urandom_range(0, 127));
      end

      // defaults after reset: min 4000 reference counts, phase limit 20
      add_row(FUNC_TICK, 0, 0, 0, 0, 0, 1'b0, '0);
      add_row(FUNC_CAPTURE, 10, 100, 1, 0, 0, 1'b1,
              {STAT_STARTED, 8'd0, 16'd0, 8'd1, 16'd0, 1'b0});
      add_row(FUNC_CAPTURE, 11, 101, 1, 0, 0, 1'b0, '0);
      add_row(FUNC_CAPTURE, 20, 4099, 1, 0, 0, 1'b0, '0);
      add_row(FUNC_CAPTURE, 20, 4100, 1, 0, 0, 1'b1,
              {STAT_DIV_ZERO, 8'd10, 16'd4000, 8'd2, 16'd0, 1'b0});
      add_row(FUNC_CAPTURE, 0, 8100, 0, 1, 0, 1'b1,
              {STAT_RESTARTED, 8'd0, 16'd0, 8'd1, 16'd0, 1'b0});
      add_row(FUNC_TICK, 0, 65535, 0, 0, 1, 1'b0, '0);
      add_row(FUNC_CAPTURE, 255, 12100, 1, 0, 0, 1'b1,
              {STAT_MEASURED, 8'd255, 16'd4000, 8'd2, 16'hFFFF, 1'b1});
      add_row(FUNC_TIMEOUT, 0, 0, 0, 0, 0, 1'b0, '0);
      add_row(FUNC_CAPTURE, 255, 65535, 1, 1, 255, 1'b1,
              {STAT_STARTED, 8'd0, 16'd0, 8'd1, 16'd0, 1'b0});
      add_row(FUNC_TICK, 255, 65535, 1, 1, 255, 1'b0, '0);
      add_row(FUNC_CAPTURE, 254, 65534, 0, 0, 0, 1'b1,
              {STAT_MEASURED, 8'd255, 16'hFFFF, 8'd0, 16'd0, 1'b0});
      add_row(FUNC_TICK, 0, 50000, 0, 0, 127, 1'b0, '0);
      add_row(FUNC_CAPTURE, 100, 4000, 1, 0, 0, 1'b0, '0);
      add_row(FUNC_CAPTURE, 3, 9000, 0, 0, 0, 1'b0, '0);
      add_row(FUNC_UNUSED, 77, 1234, 1, 1, 9, 1'b0, '0);
      add_row(FUNC_CAPTURE, 50, 13000, 1, 1, 0, 1'b0, '0);
      add_row(FUNC_TIMEOUT, 0, 0, 0, 0, 0, 1'b0, '0);
      add_row(FUNC_CAPTURE, 0, 0, 0, 0, 0, 1'b1,
              {STAT_STARTED, 8'd0, 16'd0, 8'hFF, 16'd0, 1'b0});
      add_row(FUNC_CAPTURE, 0, 4000, 0, 0, 0, 1'b1,
              {STAT_MEASURED, 8'd0, 16'd4000, 8'hFE, 16'd0, 1'b0});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res, taken);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         write_reg(CSR_MIN_REF, min_plan[ph]);
         write_reg(CSR_PHASE_LIMIT, limit_plan[ph]);
         settings_used++;
         no_idle = (ph == 3);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            it.sig = EDGE_W'($urandom);
            it.refc = REF_W'($urandom);
            it.level = 1'($urandom);
            it.ovf = 1'($urandom);
            it.slow = SLOW_W'($urandom);
            pick = int'($urandom_range(99));
            if (pick < 62) begin
               // capture placed past the gate of the open window
               it.func = FUNC_CAPTURE;
               span = 65535 - int'(min_ref_cfg);
               if (span > 3000 && $urandom_range(3) != 0) span = 3000;
               it.refc = ref_mark + min_ref_cfg + REF_W'($urandom_range(0, span));
               it.ovf = ($urandom_range(9) == 0);
            end else if (pick < 74) begin
               it.func = FUNC_TICK;
               if ($urandom_range(9) == 0) it.slow = slow_prev;
            end else if (pick < 80) begin
               it.func = FUNC_TIMEOUT;
            end else if (pick < 83) begin
               it.func = FUNC_UNUSED;
            end else begin
               it.func = FUNC_CAPTURE;
            end
            push_item(it, 1'b0, '0, taken);
            if (taken) counted++;
         end
      end
      no_idle = 1'b0;

      settle();
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
         errors++;
      end
      $display("%0d request transfers (%0d taking effect) over %0d register settings",
               items_sent, items_effective, settings_used);
      $display("%0d results checked: %0d started, %0d restarted, %0d measured",
               results_seen, status_hits[STAT_STARTED], status_hits[STAT_RESTARTED],
               status_hits[STAT_MEASURED]);
      $display("%0d measured results clamped, %0d with zero divisor",
               sat_seen, status_hits[STAT_DIV_ZERO]);
      if (errors == 0) begin
         $display("tb_reciprocal_frequency_counter_top: PASS");
      end else begin
         $display("tb_reciprocal_frequency_counter_top: FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_reciprocal_frequency_counter_top: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rfc_pkg.sv
hdl/rfc_mul.sv
hdl/rfc_calc.sv
hdl/reciprocal_frequency_counter_top.sv
hdl/rfc_checker.sv
tb/tb_reciprocal_frequency_counter_top.sv
